>>> src/roc_pkg.sv
// roc_pkg: shared constants, codes and types of the rectangle overlap classifier.
// No dependencies; every other file of the block imports it.
package roc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int NUM_STAGES     = 7;

    // Threshold registers
    localparam int             PCT_BITS      = 7;
    localparam logic [6:0]     MATCH_PCT_RST = 7'd65;
    localparam logic [6:0]     ENTER_PCT_RST = 7'd50;
    localparam logic [6:0]     PCT_SCALE     = 7'd100;
    localparam logic [6:0]     HALF_SCALE    = 7'd50;

    // Configuration register indexes
    localparam int   CFG_IDX_BITS = 1;
    localparam logic CFG_MATCH    = 1'b0;
    localparam logic CFG_ENTER    = 1'b1;

    typedef enum logic [1:0] {
        REQ_RELATION = 2'd0,
        REQ_SAME     = 2'd1,
        REQ_ENTER    = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        REL_NONE         = 2'd0,
        REL_SAME         = 2'd1,
        REL_FIRST_HOLDS  = 2'd2,
        REL_SECOND_HOLDS = 2'd3
    } t_rel;

    localparam logic [1:0] TEST_FALSE = 2'd0;
    localparam logic [1:0] TEST_TRUE  = 2'd1;

endpackage

>>> src/rect_overlap_classifier_top.sv
// rect_overlap_classifier_top: top level, threshold registers, pipeline valid/stall control.
// Depends on roc_pkg, roc_geom, roc_area and roc_ratio.
//
// Classifies a pair of axis-aligned rectangles by how much they overlap. Each input
// beat carries a request type and both rectangles (edge plus size); each beat gives
// exactly one output beat, in order. Separated rectangles always give 0. Relation
// requests return 0 unrelated, 1 same, 2 first contains second, 3 second contains
// first, judged by the match threshold; same requests test the mean of both overlap
// ratios against the match threshold; enter requests test either ratio against the
// enter threshold. A rectangle of zero area never passes a ratio test. Request type 3
// returns 0. The block is a seven-stage pipeline: one beat per cycle sustained while
// the output is not stalled; a beat passes through stages 1 to 7 in order, and o_valid
// shows the last stage. Stage depth is set by the
// area multipliers and by the 50*i*(a1+a2) versus t*a1*a2 compare, whose wide
// products are built from two half-width partial products and summed a stage later.
// A stalled output freezes only the stages that are full; bubbles behind it still
// close up. Threshold writes (index 0 match, index 1 enter, reset 65 and 50) must be
// made while the pipeline is empty.
module rect_overlap_classifier_top
    import roc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request beats
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [COORD_BITS-1:0]   i_first_x,
    input  logic [COORD_BITS-1:0]   i_first_y,
    input  logic [COORD_BITS-1:0]   i_first_width,
    input  logic [COORD_BITS-1:0]   i_first_height,
    input  logic [COORD_BITS-1:0]   i_second_x,
    input  logic [COORD_BITS-1:0]   i_second_y,
    input  logic [COORD_BITS-1:0]   i_second_width,
    input  logic [COORD_BITS-1:0]   i_second_height,
    // result beats
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_relation_code,
    // threshold writes
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [PCT_BITS-1:0]     i_cfg_data
);
    localparam int C = COORD_BITS;
    localparam int A = 2 * COORD_BITS;

    logic [PCT_BITS-1:0]   r_match_pct, r_enter_pct;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;

    // geometry -> area
    logic [1:0]   w_g_req;
    logic         w_g_sep;
    logic [C-1:0] w_g_ovx, w_g_ovy, w_g_w1, w_g_h1, w_g_w2, w_g_h2;

    // area -> ratio
    logic [1:0]   w_a_req;
    logic         w_a_sep, w_a_v1, w_a_v2;
    logic [A+6:0] w_a_i100, w_a_ma1, w_a_ma2, w_a_ea1, w_a_ea2;
    logic [A+5:0] w_a_i50;
    logic [A:0]   w_a_sum;
    logic [A-1:0] w_a_a2;

    // thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_pct <= MATCH_PCT_RST;
            r_enter_pct <= ENTER_PCT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH: r_match_pct <= i_cfg_data;
                CFG_ENTER: r_enter_pct <= i_cfg_data;
                default:   r_match_pct <= r_match_pct;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    roc_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .i_clk           (i_clk),
        .i_adv           (w_rdy[1:0]),
        .i_req_type      (i_req_type),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_width   (i_first_width),
        .i_first_height  (i_first_height),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_width  (i_second_width),
        .i_second_height (i_second_height),
        .o_req           (w_g_req),
        .o_sep           (w_g_sep),
        .o_ovx           (w_g_ovx),
        .o_ovy           (w_g_ovy),
        .o_w1            (w_g_w1),
        .o_h1            (w_g_h1),
        .o_w2            (w_g_w2),
        .o_h2            (w_g_h2)
    );

    roc_area #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .i_clk       (i_clk),
        .i_adv       (w_rdy[3:2]),
        .i_match_pct (r_match_pct),
        .i_enter_pct (r_enter_pct),
        .i_req       (w_g_req),
        .i_sep       (w_g_sep),
        .i_ovx       (w_g_ovx),
        .i_ovy       (w_g_ovy),
        .i_w1        (w_g_w1),
        .i_h1        (w_g_h1),
        .i_w2        (w_g_w2),
        .i_h2        (w_g_h2),
        .o_req       (w_a_req),
        .o_sep       (w_a_sep),
        .o_v1        (w_a_v1),
        .o_v2        (w_a_v2),
        .o_i100      (w_a_i100),
        .o_i50       (w_a_i50),
        .o_sum       (w_a_sum),
        .o_a2        (w_a_a2),
        .o_ma1       (w_a_ma1),
        .o_ma2       (w_a_ma2),
        .o_ea1       (w_a_ea1),
        .o_ea2       (w_a_ea2)
    );

    roc_ratio #(
        .COORD_BITS (COORD_BITS)
    ) u_ratio (
        .i_clk           (i_clk),
        .i_adv           (w_rdy[6:4]),
        .i_req           (w_a_req),
        .i_sep           (w_a_sep),
        .i_v1            (w_a_v1),
        .i_v2            (w_a_v2),
        .i_i100          (w_a_i100),
        .i_i50           (w_a_i50),
        .i_sum           (w_a_sum),
        .i_a2            (w_a_a2),
        .i_ma1           (w_a_ma1),
        .i_ma2           (w_a_ma2),
        .i_ea1           (w_a_ea1),
        .i_ea2           (w_a_ea2),
        .o_relation_code (o_relation_code)
    );

endmodule

>>> src/roc_geom.sv
// roc_geom: pipeline stages 1 and 2, rectangle ends, separation test, overlap lengths.
// Depends on roc_pkg.
module roc_geom
    import roc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [1:0]            i_adv,
    input  logic [1:0]            i_req_type,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_first_width,
    input  logic [COORD_BITS-1:0] i_first_height,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    input  logic [COORD_BITS-1:0] i_second_width,
    input  logic [COORD_BITS-1:0] i_second_height,
    output logic [1:0]            o_req,
    output logic                  o_sep,
    output logic [COORD_BITS-1:0] o_ovx,
    output logic [COORD_BITS-1:0] o_ovy,
    output logic [COORD_BITS-1:0] o_w1,
    output logic [COORD_BITS-1:0] o_h1,
    output logic [COORD_BITS-1:0] o_w2,
    output logic [COORD_BITS-1:0] o_h2
);
    localparam int C = COORD_BITS;

    // stage 1
    logic [1:0]   r1_req;
    logic [C-1:0] r1_x1, r1_y1, r1_x2, r1_y2;
    logic [C-1:0] r1_w1, r1_h1, r1_w2, r1_h2;
    logic [C:0]   r1_ex1, r1_ey1, r1_ex2, r1_ey2;

    // stage 2
    logic [1:0]   r2_req;
    logic         r2_sep;
    logic [C-1:0] r2_ovx, r2_ovy;
    logic [C-1:0] r2_w1, r2_h1, r2_w2, r2_h2;

    logic         n_sep;
    logic [C-1:0] n_ovx, n_ovy;

    // min(end) - max(start), clipped at zero; never exceeds either size
    function automatic logic [C-1:0] ov_len(input logic [C-1:0] s1, input logic [C-1:0] s2,
                                            input logic [C:0] e1, input logic [C:0] e2);
        logic [C-1:0] lo;
        logic [C:0]   hi;
        logic [C:0]   diff;
        lo   = (s1 > s2) ? s1 : s2;
        hi   = (e1 < e2) ? e1 : e2;
        diff = hi - {1'b0, lo};
        return (hi > {1'b0, lo}) ? diff[C-1:0] : '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_req <= i_req_type;
            r1_x1  <= i_first_x;
            r1_y1  <= i_first_y;
            r1_x2  <= i_second_x;
            r1_y2  <= i_second_y;
            r1_w1  <= i_first_width;
            r1_h1  <= i_first_height;
            r1_w2  <= i_second_width;
            r1_h2  <= i_second_height;
            r1_ex1 <= {1'b0, i_first_x} + {1'b0, i_first_width};
            r1_ey1 <= {1'b0, i_first_y} + {1'b0, i_first_height};
            r1_ex2 <= {1'b0, i_second_x} + {1'b0, i_second_width};
            r1_ey2 <= {1'b0, i_second_y} + {1'b0, i_second_height};
        end
    end

    always_comb begin
        n_sep = (r1_ex1 < {1'b0, r1_x2}) || ({1'b0, r1_x1} > r1_ex2) ||
                (r1_ey1 < {1'b0, r1_y2}) || ({1'b0, r1_y1} > r1_ey2);
        n_ovx = ov_len(r1_x1, r1_x2, r1_ex1, r1_ex2);
        n_ovy = ov_len(r1_y1, r1_y2, r1_ey1, r1_ey2);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r2_req <= r1_req;
            r2_sep <= n_sep;
            r2_ovx <= n_ovx;
            r2_ovy <= n_ovy;
            r2_w1  <= r1_w1;
            r2_h1  <= r1_h1;
            r2_w2  <= r1_w2;
            r2_h2  <= r1_h2;
        end
    end

    assign o_req = r2_req;
    assign o_sep = r2_sep;
    assign o_ovx = r2_ovx;
    assign o_ovy = r2_ovy;
    assign o_w1  = r2_w1;
    assign o_h1  = r2_h1;
    assign o_w2  = r2_w2;
    assign o_h2  = r2_h2;

endmodule

>>> src/roc_area.sv
// roc_area: pipeline stages 3 and 4, intersection and rectangle areas, threshold scaling.
// Depends on roc_pkg.
module roc_area
    import roc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [1:0]                i_adv,
    input  logic [PCT_BITS-1:0]       i_match_pct,
    input  logic [PCT_BITS-1:0]       i_enter_pct,
    input  logic [1:0]                i_req,
    input  logic                      i_sep,
    input  logic [COORD_BITS-1:0]     i_ovx,
    input  logic [COORD_BITS-1:0]     i_ovy,
    input  logic [COORD_BITS-1:0]     i_w1,
    input  logic [COORD_BITS-1:0]     i_h1,
    input  logic [COORD_BITS-1:0]     i_w2,
    input  logic [COORD_BITS-1:0]     i_h2,
    output logic [1:0]                o_req,
    output logic                      o_sep,
    output logic                      o_v1,
    output logic                      o_v2,
    output logic [2*COORD_BITS+6:0]   o_i100,
    output logic [2*COORD_BITS+5:0]   o_i50,
    output logic [2*COORD_BITS:0]     o_sum,
    output logic [2*COORD_BITS-1:0]   o_a2,
    output logic [2*COORD_BITS+6:0]   o_ma1,
    output logic [2*COORD_BITS+6:0]   o_ma2,
    output logic [2*COORD_BITS+6:0]   o_ea1,
    output logic [2*COORD_BITS+6:0]   o_ea2
);
    localparam int A  = 2 * COORD_BITS;   // area width
    localparam int SW = A + PCT_BITS;     // scaled area width

    // stage 3
    logic [1:0]   r3_req;
    logic         r3_sep;
    logic [A-1:0] r3_inter, r3_a1, r3_a2;

    // stage 4
    logic [1:0]    r4_req;
    logic          r4_sep, r4_v1, r4_v2;
    logic [SW-1:0] r4_i100, r4_ma1, r4_ma2, r4_ea1, r4_ea2;
    logic [A+5:0]  r4_i50;
    logic [A:0]    r4_sum;
    logic [A-1:0]  r4_a2;

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r3_req   <= i_req;
            r3_sep   <= i_sep;
            r3_inter <= A'(i_ovx) * A'(i_ovy);
            r3_a1    <= A'(i_w1) * A'(i_h1);
            r3_a2    <= A'(i_w2) * A'(i_h2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r4_req  <= r3_req;
            r4_sep  <= r3_sep;
            r4_v1   <= (r3_a1 != '0);
            r4_v2   <= (r3_a2 != '0);
            r4_i100 <= SW'(r3_inter) * SW'(PCT_SCALE);
            r4_i50  <= (A+6)'(r3_inter) * (A+6)'(HALF_SCALE);
            r4_sum  <= {1'b0, r3_a1} + {1'b0, r3_a2};
            r4_a2   <= r3_a2;
            r4_ma1  <= SW'(r3_a1) * SW'(i_match_pct);
            r4_ma2  <= SW'(r3_a2) * SW'(i_match_pct);
            r4_ea1  <= SW'(r3_a1) * SW'(i_enter_pct);
            r4_ea2  <= SW'(r3_a2) * SW'(i_enter_pct);
        end
    end

    assign o_req  = r4_req;
    assign o_sep  = r4_sep;
    assign o_v1   = r4_v1;
    assign o_v2   = r4_v2;
    assign o_i100 = r4_i100;
    assign o_i50  = r4_i50;
    assign o_sum  = r4_sum;
    assign o_a2   = r4_a2;
    assign o_ma1  = r4_ma1;
    assign o_ma2  = r4_ma2;
    assign o_ea1  = r4_ea1;
    assign o_ea2  = r4_ea2;

endmodule

>>> src/roc_ratio.sv
// roc_ratio: pipeline stages 5 to 7, ratio compares, split wide products, final code.
// Depends on roc_pkg.
module roc_ratio
    import roc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [2:0]                i_adv,
    input  logic [1:0]                i_req,
    input  logic                      i_sep,
    input  logic                      i_v1,
    input  logic                      i_v2,
    input  logic [2*COORD_BITS+6:0]   i_i100,
    input  logic [2*COORD_BITS+5:0]   i_i50,
    input  logic [2*COORD_BITS:0]     i_sum,
    input  logic [2*COORD_BITS-1:0]   i_a2,
    input  logic [2*COORD_BITS+6:0]   i_ma1,
    input  logic [2*COORD_BITS+6:0]   i_ma2,
    input  logic [2*COORD_BITS+6:0]   i_ea1,
    input  logic [2*COORD_BITS+6:0]   i_ea2,
    output logic [1:0]                o_relation_code
);
    localparam int C  = COORD_BITS;
    localparam int PL = 3 * C + 6;   // i50 * low half of sum
    localparam int PH = 3 * C + 7;   // other partial products
    localparam int PW = 4 * C + 7;   // full cross products

    // stage 5
    logic [1:0]    r5_req;
    logic          r5_sep, r5_v1, r5_v2;
    logic          r5_p1m, r5_p2m, r5_p1e, r5_p2e;
    logic [PL-1:0] r5_l_lo;
    logic [PH-1:0] r5_l_hi, r5_r_lo, r5_r_hi;

    // stage 6
    logic          r6_same;
    logic [1:0]    r6_code;
    logic [PW-1:0] r6_l, r6_r;

    // stage 7
    logic [1:0]    r7_code;

    logic          w_n1, w_n2;
    logic [1:0]    n_code;

    // 50*i*(a1+a2) against mt*a1*a2, each product split on a C-bit boundary
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r5_req  <= i_req;
            r5_sep  <= i_sep;
            r5_v1   <= i_v1;
            r5_v2   <= i_v2;
            r5_p1m  <= i_i100 > i_ma1;
            r5_p2m  <= i_i100 > i_ma2;
            r5_p1e  <= i_i100 > i_ea1;
            r5_p2e  <= i_i100 > i_ea2;
            r5_l_lo <= PL'(i_i50) * PL'(i_sum[C-1:0]);
            r5_l_hi <= PH'(i_i50) * PH'(i_sum[2*C:C]);
            r5_r_lo <= PH'(i_ma1) * PH'(i_a2[C-1:0]);
            r5_r_hi <= PH'(i_ma1) * PH'(i_a2[2*C-1:C]);
        end
    end

    always_comb begin
        w_n1   = r5_v1 && !r5_p1m;
        w_n2   = r5_v2 && !r5_p2m;
        n_code = REL_NONE;
        if (!r5_sep) begin
            unique case (r5_req)
                REQ_RELATION: begin
                    priority if (r5_v1 && r5_p1m && r5_v2 && r5_p2m) begin
                        n_code = REL_SAME;
                    end else if (w_n1 && r5_v2 && r5_p2m) begin
                        n_code = REL_FIRST_HOLDS;
                    end else if (r5_v1 && r5_p1m && w_n2) begin
                        n_code = REL_SECOND_HOLDS;
                    end else begin
                        n_code = REL_NONE;
                    end
                end
                REQ_SAME: begin
                    n_code = TEST_FALSE;   // settled after the wide compare
                end
                REQ_ENTER: begin
                    n_code = ((r5_v1 && r5_p1e) || (r5_v2 && r5_p2e)) ? TEST_TRUE : TEST_FALSE;
                end
                default: begin
                    n_code = TEST_FALSE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r6_same <= (r5_req == REQ_SAME) && !r5_sep && r5_v1 && r5_v2;
            r6_code <= n_code;
            r6_l    <= PW'(r5_l_lo) + {r5_l_hi, C'(0)};
            r6_r    <= PW'(r5_r_lo) + {r5_r_hi, C'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r7_code <= r6_same ? ((r6_l > r6_r) ? TEST_TRUE : TEST_FALSE) : r6_code;
        end
    end

    assign o_relation_code = r7_code;

endmodule
